// ===== hdl/lrut_pkg.sv =====
package lrut_pkg;

   localparam int DATA_BITS   = 32;
   localparam int ACTION_BITS = 2;

   localparam logic [ACTION_BITS-1:0] ACT_GET    = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_PUT    = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } cmd_type;

endpackage

// ===== hdl/lrut_ctrl.sv =====
module lrut_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lrut_pkg::cmd_type cmd
);

   lrut_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrut_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         lrut_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = lrut_pkg::ST_COMPARE;
            end
         end
         lrut_pkg::ST_COMPARE: begin
            cmd.lookup = 1'b1;
            state_in   = lrut_pkg::ST_UPDATE;
         end
         lrut_pkg::ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_stall  = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = lrut_pkg::ST_COMPARE;
               end else begin
                  state_in = lrut_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lrut_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/lrut_datapath.sv =====
module lrut_datapath #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lrut_pkg::cmd_type                   cmd,
   input  logic [lrut_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [lrut_pkg::DATA_BITS-1:0]      req_lookup_key,
   input  logic [lrut_pkg::DATA_BITS-1:0]      req_put_value,
   output logic                                rsp_hit,
   output logic [lrut_pkg::DATA_BITS-1:0]      rsp_found_value,
   output logic                                rsp_evicted,
   output logic [lrut_pkg::DATA_BITS-1:0]      rsp_evicted_key
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = lrut_pkg::DATA_BITS;

   logic [lrut_pkg::ACTION_BITS-1:0] action_ff;
   logic [KEY_BITS-1:0]              key_ff;
   logic [DW-1:0]                    value_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];
   logic [CW-1:0]      count_ff, count_in;
   logic [KEY_BITS-1:0] entry_key [ENTRIES];
   logic [DW-1:0]      value_mem [ENTRIES];

   logic [KEY_BITS+DW-1:0] key_in_wide;
   logic [KEY_BITS+DW-1:0] key_out_wide;

   logic          match_hit;
   logic [IW-1:0] match_idx, free_idx, victim_idx;
   logic          full;

   logic          hit_ff, full_ff;
   logic [IW-1:0] match_idx_ff, slot_ff;
   logic [IW-1:0] match_rank_ff;
   logic [DW-1:0] rd_value_ff, evict_key_ff;

   logic          promote;
   logic          key_we, val_we;
   logic [IW-1:0] val_waddr;

   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_evicted_ff, rsp_evicted_in;
   logic [DW-1:0] rsp_found_value_ff, rsp_found_value_in;
   logic [DW-1:0] rsp_evicted_key_ff, rsp_evicted_key_in;

   assign key_in_wide  = {{KEY_BITS{1'b0}}, req_lookup_key};
   assign key_out_wide = {{DW{1'b0}}, entry_key[victim_idx]};
   assign full         = (count_ff == CW'(ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         key_ff    <= key_in_wide[KEY_BITS-1:0];
         value_ff  <= req_put_value;
      end
   end

   always_comb begin
      match_hit  = 1'b0;
      match_idx  = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && entry_key[i] == key_ff) begin
            match_hit = 1'b1;
            match_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
         if (valid_ff[i] && CW'(rank_ff[i]) == count_ff - CW'(1)) begin
            victim_idx = IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff        <= match_hit;
         full_ff       <= full;
         match_idx_ff  <= match_idx;
         match_rank_ff <= rank_ff[match_idx];
         slot_ff       <= full ? victim_idx : free_idx;
         evict_key_ff  <= key_out_wide[DW-1:0];
         rd_value_ff   <= value_mem[match_idx];
      end
      if (val_we) begin
         value_mem[val_waddr] <= value_ff;
      end
      if (key_we) begin
         entry_key[slot_ff] <= key_ff;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      count_in  = count_ff;
      promote   = 1'b0;
      key_we    = 1'b0;
      val_we    = 1'b0;
      val_waddr = match_idx_ff;
      if (cmd.commit) begin
         unique case (action_ff)
            lrut_pkg::ACT_GET: begin
               promote = hit_ff;
            end
            lrut_pkg::ACT_PUT: begin
               if (hit_ff) begin
                  promote = 1'b1;
                  val_we  = 1'b1;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && IW'(i) != slot_ff) begin
                        rank_in[i] = IW'(rank_ff[i] + 1'b1);
                     end
                  end
                  rank_in[slot_ff]  = '0;
                  valid_in[slot_ff] = 1'b1;
                  if (!full_ff) begin
                     count_in = CW'(count_ff + 1'b1);
                  end
                  key_we    = 1'b1;
                  val_we    = 1'b1;
                  val_waddr = slot_ff;
               end
            end
            lrut_pkg::ACT_REMOVE: begin
               if (hit_ff) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && rank_ff[i] > match_rank_ff) begin
                        rank_in[i] = IW'(rank_ff[i] - 1'b1);
                     end
                  end
                  valid_in[match_idx_ff] = 1'b0;
                  rank_in[match_idx_ff]  = '0;
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
      if (promote) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && rank_ff[i] < match_rank_ff) begin
               rank_in[i] = IW'(rank_ff[i] + 1'b1);
            end
         end
         rank_in[match_idx_ff] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   always_comb begin
      rsp_hit_in         = 1'b0;
      rsp_found_value_in = '0;
      rsp_evicted_in     = 1'b0;
      rsp_evicted_key_in = '0;
      unique case (action_ff)
         lrut_pkg::ACT_GET: begin
            rsp_hit_in = hit_ff;
            if (hit_ff) begin
               rsp_found_value_in = rd_value_ff;
            end
         end
         lrut_pkg::ACT_PUT: begin
            rsp_hit_in = hit_ff;
            if (!hit_ff && full_ff) begin
               rsp_evicted_in     = 1'b1;
               rsp_evicted_key_in = evict_key_ff;
            end
         end
         lrut_pkg::ACT_REMOVE: begin
            rsp_hit_in = hit_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= rsp_hit_in;
         rsp_found_value_ff <= rsp_found_value_in;
         rsp_evicted_ff     <= rsp_evicted_in;
         rsp_evicted_key_ff <= rsp_evicted_key_in;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ===== hdl/lru_lookup_table.sv =====
// Fully associative key-to-value table of ENTRIES entries kept in least-recently-used
// order. Each accepted item passes through a compare state, which compares the key
// against every entry in parallel and reads the value memory, then an update state,
// which updates the recency ranks and writes the table while the result register is
// loaded. A new item is accepted in the update state of the previous one as long as
// the result side takes each result; a result waiting in the output register holds
// the update of the item behind it. Keys are compared on their low KEY_BITS bits.
module lru_lookup_table #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_lookup_key,
   input  logic [31:0] req_put_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_found_value,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_key
);

   lrut_pkg::cmd_type cmd;

   lrut_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lrut_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_lookup_key  (req_lookup_key),
      .req_put_value   (req_put_value),
      .rsp_hit         (rsp_hit),
      .rsp_found_value (rsp_found_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

`ifndef ASSERT_OFF
   a_accept_then_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.lookup)
      else $error("accepted item was not followed by a lookup");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed item did not present a result");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported together with a hit");

   a_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_value != 32'd0) |-> rsp_hit)
      else $error("value returned without a hit");
`endif

endmodule
